[design/plpct_pkg.sv]
package plpct_pkg;

   // request opcodes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_PIN   = 2'd2;
   localparam logic [1:0] OP_UNPIN = 2'd3;

   // fixed port widths
   localparam int OPCODE_BITS    = 2;
   localparam int REQ_TAG_BITS   = 32;
   localparam int RSP_INDEX_BITS = 4;

   typedef logic [OPCODE_BITS-1:0] opcode_type;

   // controller to datapath
   typedef struct packed {
      logic accept;     // request transfer this cycle
      logic scan_step;  // examine one slot for the victim
      logic commit;     // apply the update and load the result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic lookup_miss;  // read or write request at the port misses
      logic scan_last;    // scan is on the last slot
   } sts_type;

endpackage

[design/plpct_ctrl.sv]
module plpct_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  plpct_pkg::sts_type sts,
   output plpct_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // handshake and commands
   assign req_ready     = (state_ff == ST_IDLE);
   assign cmd.accept    = req_valid && req_ready;
   assign cmd.scan_step = (state_ff == ST_SCAN);
   assign cmd.commit    = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid     = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = sts.lookup_miss ? ST_SCAN : ST_COMMIT;
            end
         end
         ST_SCAN: begin
            if (sts.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register occupancy
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[design/plpct_dp.sv]
module plpct_dp #(
   parameter int SLOT_COUNT = 16,
   parameter int TAG_BITS   = 32,
   parameter int AGE_BITS   = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  plpct_pkg::cmd_type                       cmd,
   output plpct_pkg::sts_type                       sts,
   input  logic [plpct_pkg::OPCODE_BITS-1:0]        req_opcode,
   input  logic [plpct_pkg::REQ_TAG_BITS-1:0]       req_page_tag,
   output logic                                     rsp_hit,
   output logic                                     rsp_slot_used,
   output logic [plpct_pkg::RSP_INDEX_BITS-1:0]     rsp_slot_index,
   output logic                                     rsp_fetch_needed,
   output logic                                     rsp_writeback_needed,
   output logic [plpct_pkg::REQ_TAG_BITS-1:0]       rsp_writeback_tag,
   output logic                                     rsp_write_through,
   output logic                                     rsp_found
);

   localparam int IDX_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [AGE_BITS-1:0] AGE_MAX   = '1;
   localparam logic [IDX_BITS-1:0] LAST_SLOT = IDX_BITS'(SLOT_COUNT - 1);

   // slot state
   logic [TAG_BITS-1:0]   tags_ff   [SLOT_COUNT];
   logic [TAG_BITS-1:0]   tags_in   [SLOT_COUNT];
   logic [AGE_BITS-1:0]   age_ff    [SLOT_COUNT];
   logic [AGE_BITS-1:0]   age_in    [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic [SLOT_COUNT-1:0] pinned_ff, pinned_in;
   logic [SLOT_COUNT-1:0] dirty_ff, dirty_in;

   // request held for the operation
   plpct_pkg::opcode_type op_ff;
   logic [TAG_BITS-1:0]   tag_ff;
   logic                  hit_ff;
   logic [IDX_BITS-1:0]   hit_idx_ff;

   // victim scan
   logic [IDX_BITS-1:0]   scan_ff, scan_in;
   logic                  best_found_ff, best_found_in;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic [AGE_BITS-1:0]   best_age_ff, best_age_in;
   logic                  scan_take;

   // lookup at the port
   logic [TAG_BITS-1:0]   lookup_tag;
   logic                  match_any;
   logic [IDX_BITS-1:0]   match_idx;

   // commit decode
   logic                  is_rw;
   logic                  install;
   logic                  touch;
   logic                  wb_now;
   logic [IDX_BITS-1:0]   use_idx;

   // result register
   logic                                 hit_out_ff;
   logic                                 used_out_ff;
   logic [plpct_pkg::RSP_INDEX_BITS-1:0] idx_out_ff;
   logic                                 fetch_out_ff;
   logic                                 wb_out_ff;
   logic [plpct_pkg::REQ_TAG_BITS-1:0]   wbtag_out_ff;
   logic                                 wt_out_ff;
   logic                                 found_out_ff;

   // parallel tag compare, lowest matching slot wins
   assign lookup_tag = TAG_BITS'(req_page_tag);

   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tags_ff[i] == lookup_tag)) begin
            match_any = 1'b1;
            match_idx = IDX_BITS'(i);
         end
      end
   end

   assign sts.lookup_miss = !match_any &&
                            ((req_opcode == plpct_pkg::OP_READ) ||
                             (req_opcode == plpct_pkg::OP_WRITE));
   assign sts.scan_last   = (scan_ff == LAST_SLOT);

   // one slot per cycle: oldest unpinned, lowest index on a tie
   assign scan_take = !pinned_ff[scan_ff] &&
                      (!best_found_ff || (age_ff[scan_ff] > best_age_ff));

   always_comb begin
      scan_in       = scan_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_age_in   = best_age_ff;
      if (cmd.accept) begin
         scan_in       = '0;
         best_found_in = 1'b0;
      end else if (cmd.scan_step) begin
         scan_in = scan_ff + 1'b1;
         if (scan_take) begin
            best_found_in = 1'b1;
            best_idx_in   = scan_ff;
            best_age_in   = age_ff[scan_ff];
         end
      end
   end

   // commit decode
   assign is_rw   = (op_ff == plpct_pkg::OP_READ) || (op_ff == plpct_pkg::OP_WRITE);
   assign install = is_rw && !hit_ff && best_found_ff;
   assign touch   = is_rw && (hit_ff || best_found_ff);
   assign use_idx = hit_ff ? hit_idx_ff : best_idx_ff;
   assign wb_now  = install && valid_ff[best_idx_ff] && dirty_ff[best_idx_ff];

   // slot state update
   always_comb begin
      tags_in   = tags_ff;
      age_in    = age_ff;
      valid_in  = valid_ff;
      pinned_in = pinned_ff;
      dirty_in  = dirty_ff;
      if (cmd.commit) begin
         if (!is_rw && hit_ff) begin
            pinned_in[hit_idx_ff] = (op_ff == plpct_pkg::OP_PIN);
         end
         if (is_rw && hit_ff && (op_ff == plpct_pkg::OP_WRITE)) begin
            dirty_in[hit_idx_ff] = 1'b1;
         end
         if (install) begin
            tags_in[best_idx_ff]  = tag_ff;
            valid_in[best_idx_ff] = 1'b1;
            dirty_in[best_idx_ff] = (op_ff == plpct_pkg::OP_WRITE);
         end
         if (touch) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (IDX_BITS'(i) == use_idx) begin
                  age_in[i] = '0;
               end else if (age_ff[i] != AGE_MAX) begin
                  age_in[i] = age_ff[i] + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         pinned_ff <= '0;
         dirty_ff  <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         valid_ff  <= valid_in;
         pinned_ff <= pinned_in;
         dirty_ff  <= dirty_in;
         age_ff    <= age_in;
      end
   end

   // tags, request and scan registers
   always_ff @(posedge clock) begin
      tags_ff       <= tags_in;
      scan_ff       <= scan_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_age_ff   <= best_age_in;
      if (cmd.accept) begin
         op_ff      <= req_opcode;
         tag_ff     <= lookup_tag;
         hit_ff     <= match_any;
         hit_idx_ff <= match_idx;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_out_ff   <= hit_ff;
         used_out_ff  <= hit_ff || install;
         if (hit_ff) begin
            idx_out_ff <= plpct_pkg::RSP_INDEX_BITS'(hit_idx_ff);
         end else if (install) begin
            idx_out_ff <= plpct_pkg::RSP_INDEX_BITS'(best_idx_ff);
         end else begin
            idx_out_ff <= '0;
         end
         fetch_out_ff <= (op_ff == plpct_pkg::OP_READ) && !hit_ff;
         wb_out_ff    <= wb_now;
         wbtag_out_ff <= wb_now ? plpct_pkg::REQ_TAG_BITS'(tags_ff[best_idx_ff]) : '0;
         wt_out_ff    <= (op_ff == plpct_pkg::OP_WRITE) && !hit_ff && !best_found_ff;
         found_out_ff <= !is_rw && hit_ff;
      end
   end

   assign rsp_hit              = hit_out_ff;
   assign rsp_slot_used        = used_out_ff;
   assign rsp_slot_index       = idx_out_ff;
   assign rsp_fetch_needed     = fetch_out_ff;
   assign rsp_writeback_needed = wb_out_ff;
   assign rsp_writeback_tag    = wbtag_out_ff;
   assign rsp_write_through    = wt_out_ff;
   assign rsp_found            = found_out_ff;

endmodule

[design/pinned_lru_page_cache_tags.sv]
// channel   handshake              payload
// request   req_valid / req_ready  req_opcode, req_page_tag
// response  rsp_valid / rsp_ready  rsp_hit, rsp_slot_used, rsp_slot_index, rsp_fetch_needed,
//                                  rsp_writeback_needed, rsp_writeback_tag,
//                                  rsp_write_through, rsp_found
//
// hits, pin and unpin go from the transfer cycle (parallel tag compare) straight to commit.
// read and write misses add the victim scan between transfer and commit; the scan reads one slot age
// per cycle through a single comparator.
// one request in flight; the next request is taken while the previous response waits.
// a full response register holds the commit step until rsp_ready frees it.
// reset is synchronous; slot state needs no clearing pass, tags are ignored until valid.
module pinned_lru_page_cache_tags #(
   parameter int SLOT_COUNT = 16,
   parameter int TAG_BITS   = 32,
   parameter int AGE_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [plpct_pkg::OPCODE_BITS-1:0]    req_opcode,
   input  logic [plpct_pkg::REQ_TAG_BITS-1:0]   req_page_tag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_hit,
   output logic                                 rsp_slot_used,
   output logic [plpct_pkg::RSP_INDEX_BITS-1:0] rsp_slot_index,
   output logic                                 rsp_fetch_needed,
   output logic                                 rsp_writeback_needed,
   output logic [plpct_pkg::REQ_TAG_BITS-1:0]   rsp_writeback_tag,
   output logic                                 rsp_write_through,
   output logic                                 rsp_found
);

   plpct_pkg::cmd_type cmd;
   plpct_pkg::sts_type sts;

   plpct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   plpct_dp #(
      .SLOT_COUNT (SLOT_COUNT),
      .TAG_BITS   (TAG_BITS),
      .AGE_BITS   (AGE_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_opcode           (req_opcode),
      .req_page_tag         (req_page_tag),
      .rsp_hit              (rsp_hit),
      .rsp_slot_used        (rsp_slot_used),
      .rsp_slot_index       (rsp_slot_index),
      .rsp_fetch_needed     (rsp_fetch_needed),
      .rsp_writeback_needed (rsp_writeback_needed),
      .rsp_writeback_tag    (rsp_writeback_tag),
      .rsp_write_through    (rsp_write_through),
      .rsp_found            (rsp_found)
   );

   // a request transfer always leaves the block busy in the cycle after it
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken back to back");

   // a commit always presents a response next cycle
   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit without response");

   // a writeback only comes from an eviction
   a_writeback_on_install: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_writeback_needed) |-> (rsp_slot_used && !rsp_hit && !rsp_found))
      else $error("writeback without eviction");

   // write-through means nothing was installed
   a_write_through_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_through) |-> (!rsp_slot_used && !rsp_fetch_needed))
      else $error("write-through with a slot in use");

endmodule
